FILE: rtl/dttw_pkg.sv
package dttw_pkg;

  localparam int MAP_COLUMNS_LOG2 = 5;
  localparam int COL_W = 5;
  localparam int ROW_W = 5;
  localparam int CELL_W = 10;
  localparam int CHAR_W = 8;
  localparam int NUM_W = 16;
  localparam int PAL_W = 4;
  localparam int TILE_W = 7;
  localparam int TILE_FIELD_W = 12;
  localparam int ENTRY_W = PAL_W + TILE_FIELD_W;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int CNT_W = 5;
  localparam int PTR_W = 3;
  localparam int POS_W = 3;

  localparam logic [TILE_W-1:0] TILE_BLANK = 7'd0;
  localparam logic [TILE_W-1:0] TILE_ALPHA_UPPER = 7'd10;
  localparam logic [TILE_W-1:0] TILE_ALPHA_LOWER = 7'd36;
  localparam logic [TILE_W-1:0] TILE_DIGIT = 7'd62;
  localparam logic [TILE_W-1:0] TILE_COLON = 7'd72;
  localparam logic [TILE_W-1:0] TILE_SLASH = 7'd73;
  localparam logic [TILE_W-1:0] TILE_DOT = 7'd74;
  localparam logic [TILE_W-1:0] TILE_COMMA = 7'd75;
  localparam logic [TILE_W-1:0] TILE_MINUS = 7'd76;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic set_ptr;
    logic emit_minus;
    logic emit_digit;
    logic emit_char;
  } dttw_cmd_t;

  typedef struct packed {
    logic req_type;
    logic neg;
    logic conv_done;
    logic ptr_zero;
    logic out_free;
  } dttw_sts_t;

  function automatic logic [TILE_W-1:0] tile_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] t;
    t = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      t = ch - CH_UPPER_A + CHAR_W'(TILE_ALPHA_UPPER);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      t = ch - CH_LOWER_A + CHAR_W'(TILE_ALPHA_LOWER);
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      t = ch - CH_ZERO + CHAR_W'(TILE_DIGIT);
    end else if (ch == CH_COLON) begin
      t = CHAR_W'(TILE_COLON);
    end else if (ch == CH_SLASH) begin
      t = CHAR_W'(TILE_SLASH);
    end else if (ch == CH_DOT) begin
      t = CHAR_W'(TILE_DOT);
    end else if (ch == CH_COMMA) begin
      t = CHAR_W'(TILE_COMMA);
    end else if (ch == CH_MINUS) begin
      t = CHAR_W'(TILE_MINUS);
    end else begin
      t = CHAR_W'(TILE_BLANK);
    end
    return t[TILE_W-1:0];
  endfunction

endpackage

FILE: rtl/dttw_datapath.sv
module dttw_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dttw_pkg::dttw_cmd_t                  cmd,
  output dttw_pkg::dttw_sts_t                  sts,
  input  logic [dttw_pkg::PAL_W-1:0]           palette,
  input  logic                                 in_req_type,
  input  logic [dttw_pkg::COL_W-1:0]           in_column,
  input  logic [dttw_pkg::ROW_W-1:0]           in_row,
  input  logic [dttw_pkg::CHAR_W-1:0]          in_char_code,
  input  logic signed [dttw_pkg::NUM_W-1:0]    in_number,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dttw_pkg::CELL_W-1:0]          out_cell_index,
  output logic [dttw_pkg::ENTRY_W-1:0]         out_tile_entry,
  output logic                                 out_last
);
  import dttw_pkg::*;

  logic [CELL_W-1:0]  base_r;
  logic               type_r;
  logic               neg_r;
  logic [CHAR_W-1:0]  char_r;
  logic [NUM_W-1:0]   bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [POS_W-1:0]   pos_r;

  logic               out_valid_r;
  logic [CELL_W-1:0]  cell_r;
  logic [ENTRY_W-1:0] entry_r;
  logic               last_r;

  logic [CELL_W-1:0]  base_nxt;
  logic [NUM_W-1:0]   num_u;
  logic [NUM_W-1:0]   mag_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [PTR_W-1:0]   lead_ptr;
  logic [3:0]         cur_digit;
  logic [CELL_W-1:0]  cell_nxt;
  logic               push;
  logic [TILE_W-1:0]  tile_nxt;
  logic               last_nxt;

  assign num_u = in_number;
  assign mag_nxt = in_number[NUM_W-1] ? (NUM_W'(0) - num_u) : num_u;
  assign base_nxt = CELL_W'({in_row, {MAP_COLUMNS_LOG2{1'b0}}}) + CELL_W'(in_column);
  assign cell_nxt = base_r + CELL_W'(pos_r);

  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    priority if (bcd_r[19:16] != 4'd0) begin
      lead_ptr = 3'd4;
    end else if (bcd_r[15:12] != 4'd0) begin
      lead_ptr = 3'd3;
    end else if (bcd_r[11:8] != 4'd0) begin
      lead_ptr = 3'd2;
    end else if (bcd_r[7:4] != 4'd0) begin
      lead_ptr = 3'd1;
    end else begin
      lead_ptr = 3'd0;
    end
  end

  always_comb begin
    unique case (ptr_r)
      3'd0:    cur_digit = bcd_r[3:0];
      3'd1:    cur_digit = bcd_r[7:4];
      3'd2:    cur_digit = bcd_r[11:8];
      3'd3:    cur_digit = bcd_r[15:12];
      3'd4:    cur_digit = bcd_r[19:16];
      default: cur_digit = 4'd0;
    endcase
  end

  always_comb begin
    push = cmd.emit_minus | cmd.emit_digit | cmd.emit_char;
    if (cmd.emit_minus) begin
      tile_nxt = TILE_MINUS;
      last_nxt = 1'b0;
    end else if (cmd.emit_digit) begin
      tile_nxt = TILE_DIGIT + TILE_W'(cur_digit);
      last_nxt = (ptr_r == '0);
    end else begin
      tile_nxt = tile_of(char_r);
      last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= base_nxt;
      type_r <= in_req_type;
      neg_r  <= in_number[NUM_W-1];
      char_r <= in_char_code;
      bin_r  <= mag_nxt;
      bcd_r  <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else begin
      if (cmd.conv_step) begin
        bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[NUM_W-1]};
        bin_r <= {bin_r[NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.set_ptr) begin
        ptr_r <= lead_ptr;
      end
      if (cmd.emit_digit) begin
        ptr_r <= ptr_r - PTR_W'(1);
      end
      if (cmd.emit_minus | cmd.emit_digit) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
    if (push) begin
      cell_r  <= cell_nxt;
      entry_r <= {palette, TILE_FIELD_W'(tile_nxt)};
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.req_type  = type_r;
  assign sts.neg       = neg_r;
  assign sts.conv_done = (cnt_r == CNT_W'(NUM_W));
  assign sts.ptr_zero  = (ptr_r == '0);
  assign sts.out_free  = ~out_valid_r | out_ready;

  assign out_valid      = out_valid_r;
  assign out_cell_index = cell_r;
  assign out_tile_entry = entry_r;
  assign out_last       = last_r;

endmodule

FILE: rtl/dttw_ctrl.sv
module dttw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dttw_pkg::dttw_sts_t  sts,
  output dttw_pkg::dttw_cmd_t  cmd
);
  import dttw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (sts.req_type) begin
          state_nxt = ST_CONV;
        end else if (sts.out_free) begin
          cmd.emit_char = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CONV: begin
        if (sts.conv_done) begin
          cmd.set_ptr = 1'b1;
          state_nxt = sts.neg ? ST_SIGN : ST_DIGITS;
        end else begin
          cmd.conv_step = 1'b1;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_minus = 1'b1;
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.ptr_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/decimal_text_tile_writer_top.sv
// A character request passes a dispatch state, then its entry goes into the output
// register once the output is free; the next request is accepted after that.
// A number request takes a dispatch state and a binary to BCD conversion that ends by
// setting a pointer to the leading nonzero digit, then gives one entry per cycle while
// the output is free (a minus sign if negative, then the digits), and then goes idle.
// rst_n is synchronous and active low; it clears the palette and empties the block.
module decimal_text_tile_writer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dttw_pkg::PAL_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [dttw_pkg::COL_W-1:0]           in_column,
  input  logic [dttw_pkg::ROW_W-1:0]           in_row,
  input  logic [dttw_pkg::CHAR_W-1:0]          in_char_code,
  input  logic signed [dttw_pkg::NUM_W-1:0]    in_number,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dttw_pkg::CELL_W-1:0]          out_cell_index,
  output logic [dttw_pkg::ENTRY_W-1:0]         out_tile_entry,
  output logic                                 out_last
);
  import dttw_pkg::*;

  logic [PAL_W-1:0] palette_r;
  dttw_cmd_t        cmd;
  dttw_sts_t        sts;
  logic             in_ready_i;

  assign cfg_ready = 1'b1;
  assign in_ready  = in_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r <= '0;
    end else if (cfg_valid) begin
      palette_r <= cfg_data;
    end
  end

  dttw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready_i),
    .sts      (sts),
    .cmd      (cmd)
  );

  dttw_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .palette        (palette_r),
    .in_req_type    (in_req_type),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_char_code   (in_char_code),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_index (out_cell_index),
    .out_tile_entry (out_tile_entry),
    .out_last       (out_last)
  );

endmodule
